@@ rtl/core/cor_pkg.sv @@
// ----------------------------------------------------------------------------
// cor_pkg
// shared types and constants for the circle outline raster
// ----------------------------------------------------------------------------
package cor_pkg;

	localparam int DEF_MAX_RADIUS = 255;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 72;
	localparam int COORD_W    = 17;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_COL  = 2'd1,
		PH_ROW  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'd0,
		S_CLEAR = 3'd1,
		S_SQ    = 3'd2,
		S_ROOT  = 3'd3,
		S_FIN   = 3'd4
	} state_t;

endpackage

@@ rtl/core/cor_ram.sv @@
// ----------------------------------------------------------------------------
// cor_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cor_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/circle_outline_raster.sv @@
// ----------------------------------------------------------------------------
// circle_outline_raster
// circle outline generator, four mirrored points per result beat
// ----------------------------------------------------------------------------
// A start beat (tuser 0) latches center and radius, clears rows 0..r of the
// row-used map and returns one empty result (radius 0: clear skipped, result
// flagged last). Each tick beat (tuser 1) returns one result: the column
// pass walks k = 0..r, the row pass walks k = 0..r again and fills rows the
// column pass left unmarked; the beat closing the row pass carries tlast. In
// either pass the rounded square root has AW bits, AW = clog2(min(MAX_RADIUS,
// 255)+1), i.e. 8 at the default, and is produced one bit per cycle by a
// single shared compare/subtract unit. A tick with no circle armed returns
// an empty result. The result sits in an output register, so the next beat
// is taken while a result waits for the consumer.
module circle_outline_raster
	import cor_pkg::*;
#(
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // center_x, center_y, radius
	input  logic                  s_tuser,   // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // x_plus, x_minus, y_plus, y_minus, pad
	output logic                  m_tuser,   // point_valid
	output logic                  m_tlast    // final_res
);

	localparam int LIM   = (MAX_RADIUS < 255) ? MAX_RADIUS : 255;
	localparam int DEPTH = LIM + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(AW + 1);
	localparam logic [7:0]    LIM8 = 8'(LIM);
	localparam logic [AW-1:0] LIMA = AW'(LIM);

	state_t state_q, state_d;
	phase_t phase_q;

	logic [15:0]        cx_q, cy_q;
	logic [AW-1:0]      rad_q, step_q, clr_q;
	logic               op_q;
	logic [2*AW-1:0]    vsh_q;
	logic [AW+1:0]      rem_q;
	logic [AW-1:0]      root_q;
	logic [CW-1:0]      cnt_q;

	logic               ovalid_q, pv_q, last_q;
	logic [COORD_W-1:0] xp_q, xm_q, yp_q, ym_q;

	logic [15:0]        in_cx, in_cy;
	logic [7:0]         in_rad;
	logic [AW-1:0]      r_sat;
	logic               accept, fin_ok, fin_fire;
	logic               mem_we, mem_wdata, row_used;
	logic [AW-1:0]      mem_waddr;

	logic [AW:0]        diff, sum;
	logic [2*AW+1:0]    prod;
	logic [AW+1:0]      rem_sh, trial;
	logic               ge;
	logic [AW:0]        off_sum;
	logic [AW-1:0]      off;
	logic [COORD_W-1:0] cx17, cy17, k17, off17;

	assign in_cx  = s_tdata[15:0];
	assign in_cy  = s_tdata[31:16];
	assign in_rad = s_tdata[39:32];
	assign r_sat  = (in_rad > LIM8) ? LIMA : AW'(in_rad);

	assign accept = s_tvalid && s_tready;
	assign fin_ok = !ovalid_q || m_tready;

	// shared root unit: one result bit per cycle
	assign diff   = {1'b0, rad_q} - {1'b0, step_q};
	assign sum    = {1'b0, rad_q} + {1'b0, step_q};
	assign prod   = diff * sum;
	assign rem_sh = {rem_q[AW-1:0], vsh_q[2*AW-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	assign off_sum = {1'b0, root_q} + {{AW{1'b0}}, (rem_q > {2'b00, root_q})};
	assign off     = off_sum[AW-1:0];

	assign cx17  = {cx_q[15], cx_q};
	assign cy17  = {cy_q[15], cy_q};
	assign k17   = COORD_W'(step_q);
	assign off17 = COORD_W'(off);

	cor_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_row_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (step_q),
		.rdata (row_used)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == OP_START) begin
						state_d = (r_sat == '0) ? S_FIN : S_CLEAR;
					end else begin
						state_d = (phase_q == PH_IDLE) ? S_FIN : S_SQ;
					end
				end
			end
			S_CLEAR: begin
				if (clr_q == rad_q) begin
					state_d = S_FIN;
				end
			end
			S_SQ:   state_d = S_ROOT;
			S_ROOT: begin
				if (cnt_q == CW'(AW - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_ok) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		fin_fire  = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = 1'b0;
		mem_waddr = off;
		unique case (state_q)
			S_IDLE:  s_tready = 1'b1;
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_SQ, S_ROOT: ;
			S_FIN: begin
				fin_fire  = fin_ok;
				mem_we    = fin_ok && (op_q == OP_TICK) && (phase_q == PH_COL);
				mem_wdata = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			phase_q  <= PH_IDLE;
			step_q   <= '0;
			rad_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			op_q     <= OP_START;
			clr_q    <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= s_tuser;
				if (s_tuser == OP_START) begin
					cx_q    <= in_cx;
					cy_q    <= in_cy;
					rad_q   <= r_sat;
					step_q  <= '0;
					clr_q   <= '0;
					phase_q <= (r_sat == '0) ? PH_IDLE : PH_COL;
				end
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_SQ) begin
				cnt_q <= '0;
			end else if (state_q == S_ROOT) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (fin_fire && op_q == OP_TICK) begin
				unique case (phase_q)
					PH_COL: begin
						if (step_q >= rad_q) begin
							phase_q <= PH_ROW;
							step_q  <= '0;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
					PH_ROW: begin
						if (step_q >= rad_q) begin
							phase_q <= PH_IDLE;
							step_q  <= '0;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (fin_fire) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SQ) begin
			vsh_q  <= prod[2*AW-1:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == S_ROOT) begin
			vsh_q  <= vsh_q << 2;
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= AW'({root_q, ge});
		end
		if (fin_fire) begin
			pv_q   <= 1'b0;
			last_q <= 1'b0;
			xp_q   <= '0;
			xm_q   <= '0;
			yp_q   <= '0;
			ym_q   <= '0;
			if (op_q == OP_START) begin
				last_q <= (rad_q == '0);
			end else begin
				unique case (phase_q)
					PH_COL: begin
						pv_q <= 1'b1;
						xp_q <= cx17 + k17;
						xm_q <= cx17 - k17;
						yp_q <= cy17 + off17;
						ym_q <= cy17 - off17;
					end
					PH_ROW: begin
						last_q <= (step_q >= rad_q);
						if (!row_used) begin
							pv_q <= 1'b1;
							xp_q <= cx17 + off17;
							xm_q <= cx17 - off17;
							yp_q <= cy17 + k17;
							ym_q <= cy17 - k17;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tuser  = pv_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(OUT_DATA_W - 4*COORD_W){1'b0}}, ym_q, yp_q, xm_q, xp_q};

`ifndef SYNTH
	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q == S_FIN |-> mem_waddr <= rad_q)
		else $error("row mark beyond radius");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_CLEAR || phase_q == PH_COL)
		else $error("row map written outside clear or column pass");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == OP_START && r_sat != '0 |=> state_q == S_CLEAR)
		else $error("start did not enter clear");
`endif

endmodule

@@ tb/sv/tb_circle_outline_raster.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_outline_raster
// self-checking stream testbench for the circle outline raster
// ----------------------------------------------------------------------------
// Start and tick beats go into the block while a scoreboard predicts every
// result beat: the mirrored points of the column and row passes, skipped rows,
// empty results for starts and idle ticks, and the closing tlast. A directed
// opening is followed by random circles, mostly small, some abandoned by a new
// start, and one full circle at the largest radius. Both sides idle at random,
// the consumer holds off once for a long stretch and the producer drains the
// block between phases.
// ----------------------------------------------------------------------------
module tb_circle_outline_raster;
	import cor_pkg::*;

	typedef struct {
		logic        point_valid;
		logic [16:0] x_plus;
		logic [16:0] x_minus;
		logic [16:0] y_plus;
		logic [16:0] y_minus;
		logic        final_res;
	} point_beat_t;

	class circle_scoreboard;
		point_beat_t        pending_points[$];
		phase_t             phase;
		int unsigned        step;
		logic [7:0]         rad;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		bit                 row_used[256];
		int                 errors;

		function new();
			phase = PH_IDLE;
			step = 0;
			rad = '0;
			cx = '0;
			cy = '0;
			row_used = '{default: 1'b0};
			errors = 0;
		endfunction

		// nearest integer square root, ties cannot occur for integers
		function int unsigned root_nearest(int unsigned v);
			int unsigned s;
			int unsigned t;
			s = 0;
			for (int b = 15; b >= 0; b--) begin
				t = s | (32'd1 << b);
				if (t * t <= v)
					s = t;
			end
			return s + ((v > s * s + s) ? 1 : 0);
		endfunction

		function point_beat_t mirror(int unsigned dx, int unsigned dy);
			point_beat_t p;
			int          c;
			int          d;
			c = cx;
			d = cy;
			p.point_valid = 1'b1;
			p.x_plus  = 17'(c + int'(dx));
			p.x_minus = 17'(c - int'(dx));
			p.y_plus  = 17'(d + int'(dy));
			p.y_minus = 17'(d - int'(dy));
			p.final_res = 1'b0;
			return p;
		endfunction

		function void note_input(logic op, logic [IN_DATA_W-1:0] beat);
			point_beat_t res;
			int unsigned r2;
			int unsigned k;
			int unsigned off;
			res = '{default: '0};
			if (op == OP_START) begin
				cx = beat[15:0];
				cy = beat[31:16];
				rad = beat[39:32];
				step = 0;
				row_used = '{default: 1'b0};
				if (rad == 0) begin
					phase = PH_IDLE;
					res.final_res = 1'b1;
				end else begin
					phase = PH_COL;
				end
			end else begin
				k = step;
				r2 = rad * rad;
				if (phase == PH_COL) begin
					off = root_nearest(r2 - k * k);
					res = mirror(k, off);
					row_used[off] = 1'b1;
					if (k >= rad) begin
						phase = PH_ROW;
						step = 0;
					end else begin
						step = k + 1;
					end
				end else if (phase == PH_ROW) begin
					// rows already drawn by the column pass give an empty beat
					if (!row_used[k])
						res = mirror(root_nearest(r2 - k * k), k);
					if (k >= rad) begin
						phase = PH_IDLE;
						step = 0;
						res.final_res = 1'b1;
					end else begin
						step = k + 1;
					end
				end
			end
			pending_points.push_back(res);
		endfunction

		function void check_result(logic pv, logic [OUT_DATA_W-1:0] beat, logic last);
			point_beat_t e;
			if (pending_points.size() == 0) begin
				$error("unexpected result beat: tdata %h tuser %b tlast %b", beat, pv, last);
				errors++;
				return;
			end
			e = pending_points.pop_front();
			if (pv !== e.point_valid) begin
				$error("point_valid: expected %b, got %b", e.point_valid, pv);
				errors++;
			end
			if (beat[16:0] !== e.x_plus) begin
				$error("x_plus: expected %h, got %h", e.x_plus, beat[16:0]);
				errors++;
			end
			if (beat[33:17] !== e.x_minus) begin
				$error("x_minus: expected %h, got %h", e.x_minus, beat[33:17]);
				errors++;
			end
			if (beat[50:34] !== e.y_plus) begin
				$error("y_plus: expected %h, got %h", e.y_plus, beat[50:34]);
				errors++;
			end
			if (beat[67:51] !== e.y_minus) begin
				$error("y_minus: expected %h, got %h", e.y_minus, beat[67:51]);
				errors++;
			end
			if (last !== e.final_res) begin
				$error("final_res: expected %b, got %b", e.final_res, last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_points.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = OP_TICK;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	circle_scoreboard sb = new();
	int               sent_beats = 0;

	circle_outline_raster dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("FAIL circle_outline_raster");
		$finish;
	end

	task automatic send_beat(logic op, logic [IN_DATA_W-1:0] beat);
		// no gaps inside the quiet window
		while (!(sent_beats >= 400 && sent_beats < 560) && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= beat;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(op, beat);
		sent_beats++;
	endtask

	task automatic run_circle(logic [15:0] x, logic [15:0] y, logic [7:0] r, int ticks);
		send_beat(OP_START, {r, y, x});
		repeat (ticks)
			send_beat(OP_TICK, IN_DATA_W'({$urandom, $urandom}));
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin : result_sink
		int hold_left;
		int taken;
		bit held_once;
		hold_left = 0;
		taken = 0;
		held_once = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				sb.check_result(m_tuser, m_tdata, m_tlast);
				taken++;
			end
			if (!held_once && taken == 150) begin
				held_once = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (taken >= 400 && taken < 560) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 30);
			end
		end
	end

	initial begin : stimulus
		int          pick;
		int          n;
		int unsigned r;
		bit          big_done;
		big_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		send_beat(OP_TICK, '1);
		run_circle(16'h8000, 16'h7FFF, 8'd0, 0);
		run_circle(16'h7FFF, 16'h8000, 8'd1, 4);
		send_beat(OP_TICK, '0);
		run_circle(16'h8000, 16'h7FFF, 8'd2, 3);
		run_circle(16'h0000, 16'h0000, 8'd3, 8);
		wait_drain();

		while (sent_beats < 850) begin
			if (!big_done && sent_beats >= 250) begin
				big_done = 1'b1;
				run_circle(16'($urandom), 16'($urandom), 8'd255, 512);
				continue;
			end
			pick = $urandom_range(99);
			if (pick < 3) begin
				wait_drain();
			end else if (pick < 11) begin
				run_circle(16'($urandom), 16'($urandom), 8'd0, $urandom_range(0, 2));
			end else if (pick < 17) begin
				repeat ($urandom_range(1, 3))
					send_beat(OP_TICK, IN_DATA_W'({$urandom, $urandom}));
			end else begin
				r = ($urandom_range(9) == 0) ? $urandom_range(13, 254) : $urandom_range(1, 12);
				// most large circles are cut short by the next start
				if (r > 12)
					n = $urandom_range(1, 40);
				else if ($urandom_range(3) == 0)
					n = $urandom_range(0, 2 * r + 1);
				else
					n = 2 * r + 2 + $urandom_range(0, 1);
				run_circle(16'($urandom), 16'($urandom), 8'(r), n);
			end
		end

		wait_drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS circle_outline_raster");
		else
			$display("FAIL circle_outline_raster");
		$finish;
	end

endmodule
